### design/serial_net_port_engine_core_assert.svh
// assertion macros for the network port engine
`ifndef SERIAL_NET_PORT_ENGINE_CORE_ASSERT_SVH
`define SERIAL_NET_PORT_ENGINE_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SNPE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SNPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/snpe_pkg.sv
package snpe_pkg;

    localparam int BlockBytesDefault = 64;
    localparam int QueueDepth = 2;

    localparam logic [7:0] BusyCode = 8'd31;
    localparam logic [7:0] FreeCode = 8'd30;
    localparam logic [3:0] BitsPerByte = 4'd9;
    localparam logic [7:0] CountReset = 8'd8;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_START  = 3'd1,
        CMD_CLAIM  = 3'd2,
        CMD_ANSWER = 3'd3,
        CMD_READ   = 3'd4,
        CMD_WBIT   = 3'd5,
        CMD_FINISH = 3'd6,
        CMD_BAD    = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_CLAIM     = 3'd1,
        MODE_BUSY      = 3'd2,
        MODE_FREE      = 3'd3,
        MODE_COLLREAD  = 3'd4,
        MODE_COLLWRITE = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ARG = 2'd1,
        ST_BAD_ST  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_BUSY = 2'd0,
        REG_FREE = 2'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        BK_RUN   = 2'd0,
        BK_FETCH = 2'd1,
        BK_EMIT  = 2'd2,
        BK_CLEAR = 2'd3
    } bk_state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] block_number;
        logic [7:0]  data_byte;
        logic        claim_accepted;
        logic        bit_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  read_value;
        logic [15:0] out_block_number;
        logic [7:0]  out_byte;
        logic [6:0]  out_length;
        logic        last;
    } out_item_t;

    // classified item passed from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] block_number;
        logic [7:0]  data_byte;
        logic        claim_accepted;
        logic        bit_value;
    } work_t;

endpackage

### design/serial_net_port_engine_core.sv
// Emulated bit-serial network port. Transactions carry one command each; every
// command gives one result except finish-write in collect-write mode, which gives
// one result per stored byte (or a single empty result). Load, claim, answer and
// unknown commands are answered as the back takes them; start-read, port read and
// write-bit pass through a fetch state, since they wait on the registered read
// port of the BLOCK_BYTES-byte block store; finish-write passes through the fetch
// state and then an emit state for its results. A two-entry queue between the
// command front and the executing back lets the host keep issuing while a result
// waits. After reset the back zeroes the block store, one byte per cycle, before
// it takes the first transaction; the front accepts two transactions meanwhile
// and then holds off. Configuration: register 0 is the busy countdown, register 1
// the free countdown (a zero wraps to 256 answers); write only while idle.

module serial_net_port_engine_core
    import snpe_pkg::*;
#(
    parameter int BLOCK_BYTES = BlockBytesDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic  q_valid;
    logic  q_ready;
    work_t q_data;

    // front: accept and classify
    snpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    // back: mode machine, block store, result register
    snpe_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### design/snpe_front.sv
module snpe_front
    import snpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     q_valid,
    input  logic     q_ready,
    output work_t    q_data
);

    logic [QueueDepth-1:0] full_reg;
    work_t                 slot_reg [QueueDepth];
    logic                  wp_reg;
    logic                  rp_reg;
    work_t                 cls;

    always_comb
    begin
        cls.cmd            = cmd_t'(in_data.command);
        cls.block_number   = in_data.block_number;
        cls.data_byte      = in_data.data_byte;
        cls.claim_accepted = in_data.claim_accepted;
        cls.bit_value      = in_data.bit_value;
    end

    assign in_ready = !full_reg[wp_reg];
    assign q_valid  = full_reg[rp_reg];
    assign q_data   = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            slot_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wp_reg <= !wp_reg;
            end
            if (q_valid && q_ready)
            begin
                rp_reg <= !rp_reg;
            end
            for (int i = 0; i < QueueDepth; i++)
            begin
                if (in_valid && in_ready && wp_reg == 1'(i))
                begin
                    full_reg[i] <= 1'b1;
                end
                else if (q_valid && q_ready && rp_reg == 1'(i))
                begin
                    full_reg[i] <= 1'b0;
                end
            end
        end
    end

endmodule

### design/snpe_back.sv
`include "serial_net_port_engine_core_assert.svh"

module snpe_back
    import snpe_pkg::*;
#(
    parameter int BLOCK_BYTES = BlockBytesDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_ready,
    input  work_t     q_data,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam logic [6:0] FullLen = 7'(BLOCK_BYTES);

    logic [7:0]  mem [BLOCK_BYTES];
    logic [7:0]  rd_data_reg;

    bk_state_t   state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic [7:0]  busy_cnt_reg, free_cnt_reg;
    logic [7:0]  busy_cnt_next, free_cnt_next;
    logic [6:0]  pos_reg, len_reg, load_idx_reg, emit_idx_reg;
    logic [6:0]  pos_next, len_next, load_idx_next, emit_idx_next;
    logic [3:0]  bits_reg, bits_next;
    logic [7:0]  rot_reg, reads_reg, claim_reg;
    logic [7:0]  rot_next, reads_next, claim_next;
    logic [15:0] cur_reg, prev_reg;
    logic [15:0] cur_next, prev_next;
    logic        ready_reg, ready_next;
    logic        outv_reg, outv_next;
    out_item_t   out_reg, out_next;
    work_t       item_reg;

    // memory access
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [7:0]       mem_wd;
    logic [AW-1:0]    mem_ra;

    logic take;
    logic out_free;
    logic [6:0] emit_len;
    logic [6:0] pos_inc;

    assign out_free  = !outv_reg || out_ready;
    assign q_ready   = (state_reg == BK_RUN) && out_free;
    assign take      = q_valid && q_ready;
    assign out_valid = outv_reg;
    assign out_data  = out_reg;
    assign emit_len  = (len_reg > FullLen) ? FullLen : len_reg;
    assign pos_inc   = pos_reg + 7'd1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (take && (q_data.cmd == CMD_START || q_data.cmd == CMD_READ
                    || q_data.cmd == CMD_WBIT || q_data.cmd == CMD_FINISH))
                begin
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH:
            begin
                if (item_reg.cmd == CMD_FINISH && mode_reg == MODE_COLLWRITE)
                begin
                    state_next = BK_EMIT;
                end
                else if (out_free)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_EMIT:
            begin
                if (out_free && (emit_len == 7'd0 || emit_idx_reg + 7'd1 >= emit_len))
                begin
                    state_next = BK_RUN;
                end
            end
            BK_CLEAR:
            begin
                if (emit_idx_reg + 7'd1 >= FullLen)
                begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    // read address: set on take, held through the fetch state, and stepped while emitting
    always_comb
    begin
        mem_ra = '0;
        if (take)
        begin
            unique case (q_data.cmd)
                CMD_READ:  mem_ra = AW'(pos_inc);
                CMD_WBIT:  mem_ra = AW'(pos_reg);
                default:   mem_ra = '0;
            endcase
        end
        else if (state_reg == BK_FETCH)
        begin
            unique case (item_reg.cmd)
                CMD_READ:  mem_ra = AW'(pos_inc);
                CMD_WBIT:  mem_ra = AW'(pos_reg);
                default:   mem_ra = '0;
            endcase
        end
        else if (state_reg == BK_EMIT)
        begin
            mem_ra = out_free ? AW'(emit_idx_reg + 7'd1) : AW'(emit_idx_reg);
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        if (state_reg == BK_CLEAR)
        begin
            // zero the store after reset
            mem_we = 1'b1;
            mem_wa = AW'(emit_idx_reg);
        end
        else if (take && q_data.cmd == CMD_LOAD && !ready_reg)
        begin
            mem_we = 1'b1;
            mem_wa = AW'(load_idx_reg >= FullLen ? 7'd0 : load_idx_reg);
            mem_wd = q_data.data_byte;
        end
        else if (state_reg == BK_FETCH && item_reg.cmd == CMD_WBIT && out_free
                 && mode_reg == MODE_COLLWRITE && bits_reg != 4'd0 && pos_reg < FullLen)
        begin
            mem_we = 1'b1;
            mem_wa = AW'(pos_reg);
            mem_wd = {item_reg.bit_value, rd_data_reg[7:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
        if (take)
        begin
            item_reg <= q_data;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        busy_cnt_next = busy_cnt_reg;
        free_cnt_next = free_cnt_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        load_idx_next = load_idx_reg;
        emit_idx_next = emit_idx_reg;
        bits_next     = bits_reg;
        rot_next      = rot_reg;
        reads_next    = reads_reg;
        claim_next    = claim_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        ready_next    = ready_reg;
        outv_next     = outv_reg;
        out_next      = out_reg;

        if (outv_reg && out_ready)
        begin
            outv_next = 1'b0;
        end
        if (cfg_we)
        begin
            if (cfg_index == REG_BUSY)
            begin
                busy_cnt_next = cfg_data;
            end
            else if (cfg_index == REG_FREE)
            begin
                free_cnt_next = cfg_data;
            end
        end

        if (take)
        begin
            out_next  = '{status: ST_OK, last: 1'b1, default: '0};
            outv_next = 1'b1;
            unique case (q_data.cmd)
                CMD_LOAD:
                begin
                    if (ready_reg)
                    begin
                        out_next.status = ST_BAD_ARG;
                    end
                    else if ((load_idx_reg >= FullLen ? 7'd1 : load_idx_reg + 7'd1)
                             >= FullLen)
                    begin
                        load_idx_next = '0;
                        cur_next      = q_data.block_number;
                        pos_next      = '0;
                        len_next      = FullLen;
                        ready_next    = 1'b1;
                    end
                    else
                    begin
                        load_idx_next = (load_idx_reg >= FullLen) ? 7'd1
                                                                  : load_idx_reg + 7'd1;
                    end
                end
                CMD_CLAIM:
                begin
                    if (mode_reg == MODE_COLLWRITE)
                    begin
                        out_next.status = ST_BAD_ST;
                    end
                    else
                    begin
                        claim_next = q_data.data_byte;
                        mode_next  = MODE_CLAIM;
                    end
                end
                CMD_ANSWER:
                begin
                    if (mode_reg != MODE_CLAIM)
                    begin
                        out_next.status = ST_BAD_ST;
                    end
                    else if (!q_data.claim_accepted)
                    begin
                        reads_next = free_cnt_reg;
                        mode_next  = MODE_FREE;
                    end
                    else
                    begin
                        pos_next  = '0;
                        len_next  = '0;
                        bits_next = BitsPerByte;
                        mode_next = MODE_COLLWRITE;
                    end
                end
                CMD_BAD:
                begin
                    out_next.status = ST_BAD_ARG;
                end
                default:
                begin
                    outv_next = 1'b0;
                end
            endcase
        end
        else if (state_reg == BK_FETCH)
        begin
            unique case (item_reg.cmd)
                CMD_START:
                begin
                    if (out_free)
                    begin
                        outv_next = 1'b1;
                        out_next  = '{status: ST_OK, last: 1'b1, default: '0};
                        if (!ready_reg || len_reg != FullLen)
                        begin
                            out_next.status = ST_BAD_ST;
                        end
                        else
                        begin
                            rot_next  = rd_data_reg;
                            pos_next  = '0;
                            bits_next = BitsPerByte;
                            mode_next = MODE_COLLREAD;
                        end
                    end
                end
                CMD_READ:
                begin
                    if (out_free)
                    begin
                        outv_next = 1'b1;
                        out_next  = '{status: ST_OK, last: 1'b1, default: '0};
                        unique case (mode_reg)
                            MODE_CLAIM:
                            begin
                                out_next.read_value = claim_reg;
                                mode_next           = MODE_IDLE;
                            end
                            MODE_BUSY, MODE_FREE:
                            begin
                                out_next.read_value = (mode_reg == MODE_BUSY) ? BusyCode
                                                                               : FreeCode;
                                reads_next = reads_reg - 8'd1;
                                if (reads_reg == 8'd1)
                                begin
                                    mode_next = MODE_IDLE;
                                end
                            end
                            MODE_COLLREAD:
                            begin
                                out_next.read_value = rot_reg;
                                rot_next  = {rot_reg[0], rot_reg[7:1]};
                                bits_next = bits_reg - 4'd1;
                                if (bits_reg == 4'd1)
                                begin
                                    bits_next = BitsPerByte;
                                    pos_next  = pos_inc;
                                    if (pos_inc >= len_reg || pos_inc >= FullLen)
                                    begin
                                        ready_next = 1'b0;
                                        mode_next  = MODE_IDLE;
                                    end
                                    else
                                    begin
                                        rot_next = rd_data_reg;
                                    end
                                end
                            end
                            MODE_IDLE:
                            begin
                                out_next.read_value = FreeCode;
                                if (ready_reg)
                                begin
                                    if (cur_reg == prev_reg)
                                    begin
                                        mode_next  = MODE_FREE;
                                        reads_next = free_cnt_reg;
                                    end
                                    else
                                    begin
                                        mode_next  = MODE_BUSY;
                                        reads_next = busy_cnt_reg;
                                    end
                                    prev_next = cur_reg;
                                end
                            end
                            default:
                            begin
                                out_next.status = ST_BAD_ST;
                            end
                        endcase
                    end
                end
                CMD_WBIT:
                begin
                    if (out_free)
                    begin
                        outv_next = 1'b1;
                        out_next  = '{status: ST_OK, last: 1'b1, default: '0};
                        if (mode_reg != MODE_COLLWRITE)
                        begin
                            out_next.status = ST_BAD_ST;
                        end
                        else if (bits_reg == 4'd0)
                        begin
                            bits_next = BitsPerByte;
                            if (pos_reg < FullLen)
                            begin
                                pos_next = pos_inc;
                            end
                        end
                        else
                        begin
                            if (pos_reg < FullLen && len_reg < pos_inc)
                            begin
                                len_next = pos_inc;
                            end
                            bits_next = bits_reg - 4'd1;
                        end
                    end
                end
                CMD_FINISH:
                begin
                    emit_idx_next = '0;
                    if (mode_reg != MODE_COLLWRITE && out_free)
                    begin
                        outv_next = 1'b1;
                        out_next  = '{status: ST_BAD_ST, last: 1'b1, default: '0};
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == BK_EMIT && out_free)
        begin
            outv_next                 = 1'b1;
            out_next                  = '0;
            out_next.out_block_number = cur_reg + 16'd1;
            out_next.out_length       = emit_len;
            out_next.out_byte         = (emit_len == 7'd0) ? 8'd0 : rd_data_reg;
            emit_idx_next             = emit_idx_reg + 7'd1;
            if (emit_len == 7'd0 || emit_idx_reg + 7'd1 >= emit_len)
            begin
                out_next.last = 1'b1;
                cur_next      = cur_reg + 16'd1;
                prev_next     = cur_reg + 16'd1;
                mode_next     = MODE_IDLE;
                ready_next    = 1'b0;
                pos_next      = '0;
                len_next      = '0;
                bits_next     = BitsPerByte;
            end
        end
        else if (state_reg == BK_CLEAR)
        begin
            emit_idx_next = emit_idx_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_CLEAR;
            mode_reg     <= MODE_IDLE;
            busy_cnt_reg <= CountReset;
            free_cnt_reg <= CountReset;
            pos_reg      <= '0;
            len_reg      <= '0;
            load_idx_reg <= '0;
            emit_idx_reg <= '0;
            bits_reg     <= BitsPerByte;
            rot_reg      <= '0;
            reads_reg    <= '0;
            claim_reg    <= '0;
            cur_reg      <= '0;
            prev_reg     <= '0;
            ready_reg    <= 1'b0;
            outv_reg     <= 1'b0;
            out_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            busy_cnt_reg <= busy_cnt_next;
            free_cnt_reg <= free_cnt_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            load_idx_reg <= load_idx_next;
            emit_idx_reg <= emit_idx_next;
            bits_reg     <= bits_next;
            rot_reg      <= rot_next;
            reads_reg    <= reads_next;
            claim_reg    <= claim_next;
            cur_reg      <= cur_next;
            prev_reg     <= prev_next;
            ready_reg    <= ready_next;
            outv_reg     <= outv_next;
            out_reg      <= out_next;
        end
    end

    `SNPE_ASSERT_IMPL(a_ready_run, q_ready, state_reg == BK_RUN, "took item outside run")
    `SNPE_ASSERT_IMPL(a_len_max, 1'b1, len_reg <= FullLen, "store length over block size")
    `SNPE_ASSERT_NEXT(a_emit_mode, state_reg == BK_EMIT && !(state_next == BK_RUN),
        mode_reg == MODE_COLLWRITE, "emit left collect-write early")
    `SNPE_ASSERT_IMPL(a_bits_max, 1'b1, bits_reg <= BitsPerByte, "bit count over nine")

endmodule
